### design/dlpo_pkg.sv
// shared types and constants of the dust sensor low pulse occupancy averager
// no dependencies; imported by the divider, datapath, controller and top level
`default_nettype none

package dlpo_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOWS   = 4'd1;

   localparam logic [15:0] PERIOD_RESET  = 16'd30000;
   localparam logic [4:0]  WINDOWS_RESET = 5'd5;
   localparam logic [4:0]  WINDOWS_MAX   = 5'd16;

   // result limits
   localparam logic [22:0] PCT_MAX  = 23'd6553600;
   localparam logic [28:0] CONC_MAX = 29'd304640159;

   // shared restoring divider: 45-bit dividend, 16-bit divisor, 29-bit quotient
   localparam int DIV_N_W = 45;
   localparam int DIV_D_W = 16;
   localparam int DIV_Q_W = 29;

   // polynomial offset, 62 << 16
   localparam logic [DIV_N_W-1:0] CONC_OFFSET  = 45'd4063232;

   // polynomial scale: sum / 25600 = (sum >> 10) / 25
   // upper and lower 16-bit halves split with 2^16 = 25 * 2621 + 11,
   // the small remainder part divided by a reciprocal exact below 2^21
   localparam int          SCALE_SHIFT  = 10;
   localparam logic [11:0] SCALE_HI_MUL = 12'd2621;
   localparam logic [3:0]  SCALE_LO_MUL = 4'd11;
   localparam logic [21:0] RECIP_25     = 22'd2684355;   // ceil(2^26 / 25)
   localparam int          RECIP_SHIFT  = 26;

   typedef enum logic [1:0] {
      DIV_SEL_PCT,
      DIV_SEL_AVG
   } div_sel_type;

   typedef struct packed {
      logic        tick;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_pct;
      logic        calc_sq;
      logic        calc_cube;
      logic        calc_sum1;
      logic        calc_sum2;
      logic        calc_scale;
      logic        cap_conc;
      logic        cap_avg;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic close;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

### design/dust_lpo_concentration_averager_unit.sv
// Dust sensor low pulse occupancy averager, top level.
//
// req_ channel: one transaction per millisecond tick, carrying the sensor pin
// level. A falling edge starts low-time counting, a rising edge stops it.
// rsp_ channel: one transaction per closed window (every period_ms ticks):
// low percent (Q7.16), window concentration (Q21.8), running mean including
// this window, and a report flag on every windows_per_report-th window, after
// which the mean is cleared.
// csr_ channel: index 0 writes period_ms, index 1 windows_per_report. Always
// ready; write only while no window close is in progress.
//
// Timing: a tick that does not close a window leaves req_stall low. A closing
// tick holds req_stall through two passes of the shared restoring divider
// (percent, then mean), each a start, 29 quotient steps and done, the multiply
// and add steps between them (the divide by 25600 is a shift and a reciprocal
// multiply) and a final state that loads the output register. req_stall drops
// in the same cycle that the result becomes valid.
// Ticks keep being taken while a result waits under rsp_stall; a later closing
// tick finishes its arithmetic and waits until the output register is free.
// Reset (synchronous) restores period 30000, group size 5, pin idle high and
// clears counters, mean and any pending result.
`default_nettype none

module dust_lpo_concentration_averager_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tick input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_pin_level,
   // window result
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [22:0]                            rsp_low_percent,
   output logic [28:0]                            rsp_sample_conc,
   output logic [28:0]                            rsp_average_conc,
   output logic                                   rsp_report,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dlpo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dlpo_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dlpo_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   dlpo_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dlpo_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .pin_level    (req_pin_level),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .low_percent  (rsp_low_percent),
      .sample_conc  (rsp_sample_conc),
      .average_conc (rsp_average_conc),
      .report       (rsp_report)
   );

endmodule

`default_nettype wire

### design/dlpo_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on dlpo_pkg for widths; dividend must satisfy (num >> DIV_Q_W) < den
`default_nettype none

module dlpo_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [dlpo_pkg::DIV_N_W-1:0]   num,
   input  wire logic [dlpo_pkg::DIV_D_W-1:0]   den,
   output logic                                done,
   output logic [dlpo_pkg::DIV_Q_W-1:0]        quotient
);
   import dlpo_pkg::*;

   localparam int CNT_W = $clog2(DIV_Q_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_Q_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   work_ff, work_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 qbit;

   // one restoring step
   always_comb begin
      trial = {rem_ff, work_ff[DIV_Q_W-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[DIV_N_W-1:DIV_Q_W];
         work_in = num[DIV_Q_W-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         work_in = {work_ff[DIV_Q_W-2:0], qbit};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

`default_nettype wire

### design/dlpo_datapath.sv
// datapath: configuration, tick counters, percent, polynomial, running mean,
// result registers; depends on dlpo_pkg and dlpo_divider
`default_nettype none

module dlpo_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire dlpo_pkg::dp_cmd_type              cmd,
   output dlpo_pkg::dp_status_type                status,
   input  wire logic                              pin_level,
   input  wire logic                              csr_write,
   input  wire logic [dlpo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dlpo_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [22:0]                            low_percent,
   output logic [28:0]                            sample_conc,
   output logic [28:0]                            average_conc,
   output logic                                   report
);
   import dlpo_pkg::*;

   // configuration
   logic [15:0] period_ff;
   logic [4:0]  windows_ff;
   logic [15:0] eff_period;
   logic [4:0]  eff_group;

   // tick state
   logic        last_level_ff;
   logic        counting_ff;
   logic [15:0] low_ms_ff;
   logic [15:0] tick_count_ff;
   logic        counting_in;
   logic [15:0] low_ms_in;
   logic [15:0] tick_count_in;

   // window state
   logic [28:0] average_ff;
   logic [3:0]  window_count_ff;

   // window close pipeline
   logic [15:0] low_snap_ff;
   logic [22:0] pct_ff;
   logic [29:0] p2_ff;
   logic [36:0] p3_ff;
   logic [DIV_N_W-1:0] sum_ff;
   logic [28:0] conc_hi_ff;
   logic [20:0] conc_lo_ff;
   logic [28:0] conc_ff;
   logic [28:0] avg_new_ff;

   // result registers
   logic [22:0] out_pct_ff;
   logic [28:0] out_conc_ff;
   logic [28:0] out_avg_ff;
   logic        out_rep_ff;

   logic [22:0]        pct_prod;
   logic [45:0]        sq_prod;
   logic [52:0]        cube_prod;
   logic [DIV_N_W-1:0] sum1;
   logic [DIV_N_W-1:0] sum2;
   logic [32:0]        scaled;
   logic [28:0]        scale_hi_prod;
   logic [20:0]        scale_lo_sum;
   logic [42:0]        recip_prod;
   logic [29:0]        conc_sum;
   logic [33:0]        avg_num;
   logic [4:0]         n_plus_one;
   logic               rep;

   logic [DIV_N_W-1:0] div_num;
   logic [DIV_D_W-1:0] div_den;
   logic               div_done;
   logic [DIV_Q_W-1:0] div_q;

   // effective register values
   always_comb begin
      eff_period = (period_ff == 16'd0) ? 16'd1 : period_ff;
      if (windows_ff == 5'd0)
         eff_group = 5'd1;
      else if (windows_ff > WINDOWS_MAX)
         eff_group = WINDOWS_MAX;
      else
         eff_group = windows_ff;
   end

   // edge detection and counters for this tick
   always_comb begin
      counting_in = counting_ff;
      if (last_level_ff && !pin_level)
         counting_in = 1'b1;
      else if (!last_level_ff && pin_level)
         counting_in = 1'b0;
      low_ms_in = (counting_in && low_ms_ff != 16'hFFFF) ? low_ms_ff + 16'd1 : low_ms_ff;
      tick_count_in = (tick_count_ff != 16'hFFFF) ? tick_count_ff + 16'd1 : tick_count_ff;
   end

   assign status.close    = (tick_count_in >= eff_period);
   assign status.div_done = div_done;

   // arithmetic between stages
   always_comb begin
      pct_prod   = {7'd0, low_snap_ff} * 23'd100;
      sq_prod    = {23'd0, pct_ff} * {23'd0, pct_ff};
      cube_prod  = {23'd0, p2_ff} * {30'd0, pct_ff};
      sum1       = {8'd0, p3_ff} * 45'd110 + {15'd0, p2_ff} * 45'd380;
      sum2       = sum_ff + {22'd0, pct_ff} * 45'd52000 + CONC_OFFSET;
      avg_num    = {5'd0, average_ff} * {30'd0, window_count_ff} + {5'd0, conc_ff};
      n_plus_one = {1'b0, window_count_ff} + 5'd1;
      rep        = (n_plus_one >= eff_group);
   end

   // divide by 25600: drop ten bits, then split the divide by 25 into halves
   always_comb begin
      scaled        = sum_ff[SCALE_SHIFT+32:SCALE_SHIFT];
      scale_hi_prod = {12'd0, scaled[32:16]} * {17'd0, SCALE_HI_MUL};
      scale_lo_sum  = {4'd0, scaled[32:16]} * {17'd0, SCALE_LO_MUL} + {5'd0, scaled[15:0]};
      recip_prod    = {22'd0, conc_lo_ff} * {21'd0, RECIP_25};
      conc_sum      = {1'b0, conc_hi_ff} + {13'd0, recip_prod[42:RECIP_SHIFT]};
   end

   // divider operand selection
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_PCT: begin
            div_num = {6'd0, pct_prod, 16'd0};
            div_den = eff_period;
         end
         DIV_SEL_AVG: begin
            div_num = {11'd0, avg_num};
            div_den = {11'd0, n_plus_one};
         end
         default: begin
            div_num = '0;
            div_den = {{(DIV_D_W-1){1'b0}}, 1'b1};
         end
      endcase
   end

   dlpo_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // configuration, tick and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RESET;
         windows_ff      <= WINDOWS_RESET;
         last_level_ff   <= 1'b1;
         counting_ff     <= 1'b0;
         low_ms_ff       <= '0;
         tick_count_ff   <= '0;
         average_ff      <= '0;
         window_count_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_PERIOD_MS: period_ff  <= csr_data;
               CSR_WINDOWS:   windows_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (cmd.tick) begin
            last_level_ff <= pin_level;
            if (status.close) begin
               counting_ff   <= 1'b0;
               low_ms_ff     <= '0;
               tick_count_ff <= '0;
            end else begin
               counting_ff   <= counting_in;
               low_ms_ff     <= low_ms_in;
               tick_count_ff <= tick_count_in;
            end
         end
         if (cmd.out_load) begin
            average_ff      <= rep ? 29'd0 : avg_new_ff;
            window_count_ff <= rep ? 4'd0 : window_count_ff + 4'd1;
         end
      end
   end

   // window close pipeline and result registers
   always_ff @(posedge clock) begin
      if (cmd.tick && status.close)
         low_snap_ff <= low_ms_in;
      if (cmd.cap_pct)
         pct_ff <= (low_snap_ff >= eff_period) ? PCT_MAX : div_q[22:0];
      if (cmd.calc_sq)
         p2_ff <= sq_prod[45:16];
      if (cmd.calc_cube)
         p3_ff <= cube_prod[52:16];
      if (cmd.calc_sum1)
         sum_ff <= sum1;
      else if (cmd.calc_sum2)
         sum_ff <= sum2;
      if (cmd.calc_scale) begin
         conc_hi_ff <= scale_hi_prod;
         conc_lo_ff <= scale_lo_sum;
      end
      if (cmd.cap_conc)
         conc_ff <= (conc_sum > {1'b0, CONC_MAX}) ? CONC_MAX : conc_sum[28:0];
      if (cmd.cap_avg)
         avg_new_ff <= (div_q > CONC_MAX) ? CONC_MAX : div_q;
      if (cmd.out_load) begin
         out_pct_ff  <= pct_ff;
         out_conc_ff <= conc_ff;
         out_avg_ff  <= avg_new_ff;
         out_rep_ff  <= rep;
      end
   end

   assign low_percent  = out_pct_ff;
   assign sample_conc  = out_conc_ff;
   assign average_conc = out_avg_ff;
   assign report       = out_rep_ff;

endmodule

`default_nettype wire

### design/dlpo_controller.sv
// controller: input handshake, window close sequence, result valid
// depends on dlpo_pkg for the command and status structs
`default_nettype none

module dlpo_controller (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output dlpo_pkg::dp_cmd_type          cmd,
   input  wire dlpo_pkg::dp_status_type  status
);
   import dlpo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PCT_GO,
      S_PCT_WAIT,
      S_SQ,
      S_CUBE,
      S_SUM1,
      S_SUM2,
      S_SCALE,
      S_CONC,
      S_AVG_GO,
      S_AVG_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // command decode and next state
   always_comb begin
      cmd          = '0;
      cmd.div_sel  = DIV_SEL_PCT;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.tick = accept;
            if (accept && status.close)
               state_in = S_PCT_GO;
         end
         S_PCT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_PCT;
            state_in      = S_PCT_WAIT;
         end
         S_PCT_WAIT: begin
            if (status.div_done) begin
               cmd.cap_pct = 1'b1;
               state_in    = S_SQ;
            end
         end
         S_SQ: begin
            cmd.calc_sq = 1'b1;
            state_in    = S_CUBE;
         end
         S_CUBE: begin
            cmd.calc_cube = 1'b1;
            state_in      = S_SUM1;
         end
         S_SUM1: begin
            cmd.calc_sum1 = 1'b1;
            state_in      = S_SUM2;
         end
         S_SUM2: begin
            cmd.calc_sum2 = 1'b1;
            state_in      = S_SCALE;
         end
         S_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in       = S_CONC;
         end
         S_CONC: begin
            cmd.cap_conc = 1'b1;
            state_in     = S_AVG_GO;
         end
         S_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_AVG;
            state_in      = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (status.div_done) begin
               cmd.cap_avg = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid: set on load, held while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
